/* hdl/tdfa_pkg.sv */
package tdfa_pkg;

    // Field widths of the stream items
    localparam int IDX_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 3;
    localparam int VERDICT_W = 2;

    // Character map spans every byte value
    localparam int MAP_DEPTH = 256;

    // Default automaton size
    localparam int DEF_NUM_STATES  = 64;
    localparam int DEF_NUM_SYMBOLS = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TRANS = 3'd0,
        CMD_LOAD_MAP   = 3'd1,
        CMD_SET_ACCEPT = 3'd2,
        CMD_BEGIN      = 3'd3,
        CMD_STEP       = 3'd4
    } t_cmd;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ONGOING  = 2'd0,
        VERDICT_REJECTED = 2'd1,
        VERDICT_ACCEPTED = 2'd2,
        VERDICT_INVALID  = 2'd3
    } t_verdict;

endpackage

/* hdl/tdfa_in_if.sv */
interface tdfa_in_if;
    import tdfa_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  state_idx;
    logic [IDX_W-1:0]  sym_idx;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  next_state;
    logic              flag;
    logic              last;

    modport source (
        output valid, cmd, state_idx, sym_idx, char_code, next_state, flag, last,
        input  ready
    );

    modport sink (
        input  valid, cmd, state_idx, sym_idx, char_code, next_state, flag, last,
        output ready
    );
endinterface

/* hdl/tdfa_out_if.sv */
interface tdfa_out_if;
    import tdfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     from_state;
    logic [IDX_W-1:0]     to_state;
    logic [IDX_W-1:0]     symbol;
    logic [VERDICT_W-1:0] verdict;

    modport source (
        output valid, from_state, to_state, symbol, verdict,
        input  ready
    );

    modport sink (
        input  valid, from_state, to_state, symbol, verdict,
        output ready
    );
endinterface

/* hdl/tdfa_trans_mem.sv */
module tdfa_trans_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, returns old data on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/table_driven_dfa_engine.sv */
// Programmable DFA over a byte stream. Each beat on i_in carries one command: load a
// transition, load a character map entry, set an accept flag, begin a string, or step
// one character; only a step yields a beat on o_out (from/to state, symbol, verdict).
// The engine takes one beat per clock while i_in.ready is high, steps included, back
// to back: the transition RAM's registered read data is fed straight back as the row
// address of the next lookup, with no other register in that loop. A step's result
// goes through the map read at the accept edge, transition read, result register. A
// two-entry output buffer lets input beats keep flowing while one result waits;
// i_in.ready drops only when both entries are full. Reset clears the character map
// valid bits, the accept flags and the current state; the transition table has no
// reset and must be loaded before a step reads it. Write the start state register
// only while the engine is idle.
module table_driven_dfa_engine #(
    parameter int NUM_STATES  = tdfa_pkg::DEF_NUM_STATES,
    parameter int NUM_SYMBOLS = tdfa_pkg::DEF_NUM_SYMBOLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tdfa_pkg::IDX_W-1:0] i_cfg_wdata,
    tdfa_in_if.sink                   i_in,
    tdfa_out_if.source                o_out
);
    import tdfa_pkg::*;

    // Only the first 64 states and symbols are addressable by the 6-bit fields
    localparam int IDX_SPAN    = 2 ** IDX_W;
    localparam int EFF_STATES  = (NUM_STATES > IDX_SPAN) ? IDX_SPAN : NUM_STATES;
    localparam int EFF_SYMBOLS = (NUM_SYMBOLS > IDX_SPAN) ? IDX_SPAN : NUM_SYMBOLS;
    localparam int SW          = (EFF_STATES > 1) ? $clog2(EFF_STATES) : 1;
    localparam int YW          = (EFF_SYMBOLS > 1) ? $clog2(EFF_SYMBOLS) : 1;
    localparam int FLAG_DEPTH  = 2 ** SW;
    localparam logic [7:0]       NSTATES8   = 8'(NUM_STATES);
    localparam logic [7:0]       NSYMBOLS8  = 8'(NUM_SYMBOLS);
    localparam logic [IDX_W-1:0] LAST_STATE = IDX_W'((NUM_STATES - 1) % IDX_SPAN);

    logic en;
    logic acc;

    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] cur_eff;
    logic [IDX_W-1:0] start_sat;

    // Character map: valid bits in flops, symbols in a RAM
    logic [MAP_DEPTH-1:0] r_map_vld;
    logic [IDX_W-1:0]     r_map_mem [MAP_DEPTH];
    logic                 in_sym_ok;

    // Stage A: captured beat plus map lookup
    logic             r_a_vld;
    logic [CMD_W-1:0] r_a_cmd;
    logic [IDX_W-1:0] r_a_sidx;
    logic [IDX_W-1:0] r_a_yidx;
    logic [IDX_W-1:0] r_a_next;
    logic             r_a_flag;
    logic             r_a_last;
    logic             r_a_mvld;
    logic [IDX_W-1:0] r_a_msym;
    logic             a_step;
    logic             a_begin;
    logic             a_trans_ok;

    // Transition RAM
    logic             tr_we;
    logic [SW+YW-1:0] tr_waddr;
    logic [SW+YW-1:0] tr_raddr;
    logic [IDX_W-1:0] tr_rdata;

    // Stage B: transition read done
    logic             r_b_vld;
    logic             r_b_trans;
    logic             r_b_mvld;
    logic             r_b_last;
    logic [IDX_W-1:0] r_b_from;
    logic [IDX_W-1:0] r_b_sym;
    logic             r_b_acc_wr;
    logic [IDX_W-1:0] r_b_sidx;
    logic             r_b_flag;
    logic [IDX_W-1:0] b_to;
    logic [IDX_W-1:0] b_sym;
    t_verdict         b_verdict;

    logic [FLAG_DEPTH-1:0] r_accept;

    // Output register and skid entry
    logic             r_o_vld;
    logic [IDX_W-1:0] r_o_from;
    logic [IDX_W-1:0] r_o_to;
    logic [IDX_W-1:0] r_o_sym;
    t_verdict         r_o_verdict;
    logic             r_s_vld;
    logic [IDX_W-1:0] r_s_from;
    logic [IDX_W-1:0] r_s_to;
    logic [IDX_W-1:0] r_s_sym;
    t_verdict         r_s_verdict;
    logic             new_res;

    // Advance the whole pipe unless the skid entry is occupied
    assign en         = !r_s_vld;
    assign i_in.ready = en;
    assign acc        = i_in.valid && en;

    // Start state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
        end
    end

    assign start_sat = ({2'b00, r_start} < NSTATES8) ? r_start : LAST_STATE;

    // Character map writes and lookup at the accept edge
    assign in_sym_ok = ({2'b00, i_in.sym_idx} < NSYMBOLS8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (acc && i_in.cmd == CMD_LOAD_MAP && in_sym_ok) begin
            r_map_vld[i_in.char_code] <= i_in.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_in.cmd == CMD_LOAD_MAP && in_sym_ok) begin
            r_map_mem[i_in.char_code] <= i_in.sym_idx;
        end
        if (acc) begin
            r_a_msym <= r_map_mem[i_in.char_code];
        end
    end

    // Stage A capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_cmd  <= i_in.cmd;
            r_a_sidx <= i_in.state_idx;
            r_a_yidx <= i_in.sym_idx;
            r_a_next <= i_in.next_state;
            r_a_flag <= i_in.flag;
            r_a_last <= i_in.last;
            r_a_mvld <= r_map_vld[i_in.char_code];
        end
    end

    // Current state: a transition still in stage B wins over the held copy
    assign cur_eff = r_b_trans ? tr_rdata : r_cur;

    assign a_step     = r_a_vld && r_a_cmd == CMD_STEP;
    assign a_begin    = r_a_vld && r_a_cmd == CMD_BEGIN;
    assign a_trans_ok = ({2'b00, r_a_sidx} < NSTATES8) && ({2'b00, r_a_yidx} < NSYMBOLS8)
                        && ({2'b00, r_a_next} < NSTATES8);

    assign tr_we    = en && r_a_vld && r_a_cmd == CMD_LOAD_TRANS && a_trans_ok;
    assign tr_waddr = {r_a_sidx[SW-1:0], r_a_yidx[YW-1:0]};
    assign tr_raddr = {cur_eff[SW-1:0], r_a_msym[YW-1:0]};

    tdfa_trans_mem #(
        .ADDR_W (SW + YW),
        .DATA_W (IDX_W)
    ) u_trans_mem (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (r_a_next),
        .i_re    (en),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    // Stage B control and current state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld    <= 1'b0;
            r_b_trans  <= 1'b0;
            r_b_acc_wr <= 1'b0;
            r_cur      <= '0;
        end else if (en) begin
            r_b_vld    <= a_step;
            r_b_trans  <= a_step && r_a_mvld;
            r_b_acc_wr <= r_a_vld && r_a_cmd == CMD_SET_ACCEPT
                          && ({2'b00, r_a_sidx} < NSTATES8);
            r_cur      <= a_begin ? start_sat : cur_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_from <= cur_eff;
            r_b_sym  <= r_a_msym;
            r_b_mvld <= r_a_mvld;
            r_b_last <= r_a_last;
            r_b_sidx <= r_a_sidx;
            r_b_flag <= r_a_flag;
        end
    end

    // Accept flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept <= '0;
        end else if (en && r_b_acc_wr) begin
            r_accept[r_b_sidx[SW-1:0]] <= r_b_flag;
        end
    end

    // Form the result of a step
    assign b_to  = r_b_mvld ? tr_rdata : r_b_from;
    assign b_sym = r_b_mvld ? r_b_sym : '0;

    always_comb begin
        if (!r_b_mvld) begin
            b_verdict = VERDICT_INVALID;
        end else if (r_b_last) begin
            b_verdict = r_accept[b_to[SW-1:0]] ? VERDICT_ACCEPTED : VERDICT_REJECTED;
        end else begin
            b_verdict = VERDICT_ONGOING;
        end
    end

    assign new_res = en && r_b_vld;

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (!r_o_vld || o_out.ready) begin
            r_o_vld <= r_s_vld || new_res;
            r_s_vld <= 1'b0;
        end else if (new_res) begin
            r_s_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || o_out.ready) begin
            if (r_s_vld) begin
                r_o_from    <= r_s_from;
                r_o_to      <= r_s_to;
                r_o_sym     <= r_s_sym;
                r_o_verdict <= r_s_verdict;
            end else begin
                r_o_from    <= r_b_from;
                r_o_to      <= b_to;
                r_o_sym     <= b_sym;
                r_o_verdict <= b_verdict;
            end
        end else if (new_res) begin
            r_s_from    <= r_b_from;
            r_s_to      <= b_to;
            r_s_sym     <= b_sym;
            r_s_verdict <= b_verdict;
        end
    end

    assign o_out.valid      = r_o_vld;
    assign o_out.from_state = r_o_from;
    assign o_out.to_state   = r_o_to;
    assign o_out.symbol     = r_o_sym;
    assign o_out.verdict    = r_o_verdict;
endmodule
